FILE: rtl/wsasc_pkg.sv
// Shared types and constants of the wide signed add, subtract and compare unit.
package wsasc_pkg;

   localparam int unsigned IN_WORD_W  = 64;
   localparam int unsigned OUT_W      = 256;
   localparam int unsigned LEN_OUT_W  = 6;
   localparam int unsigned ORDER_W    = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_NEG = 2'd2,
      OP_CMP = 2'd3
   } opcode_type;

   typedef logic signed [ORDER_W-1:0] order_type;

   localparam order_type ORDER_LESS    = -2'sd1;
   localparam order_type ORDER_EQUAL   = 2'sd0;
   localparam order_type ORDER_GREATER = 2'sd1;

   // Control that travels alongside the data through every stage.
   typedef struct packed {
      logic       valid;
      opcode_type op;
   } stage_ctl_type;

endpackage

FILE: rtl/wsasc_adder.sv
// Shared wide adder stage: one carry chain serves add, subtract, negate and compare.
module wsasc_adder #(
   parameter int unsigned DATA_W = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wsasc_pkg::stage_ctl_type  ctl,
   input  logic [DATA_W-1:0]         first_op,
   input  logic [DATA_W-1:0]         second_op,
   output wsasc_pkg::stage_ctl_type  ctl_out,
   output logic [DATA_W:0]           sum_out
);
   import wsasc_pkg::*;

   logic [DATA_W:0] first_ext;
   logic [DATA_W:0] second_ext;
   logic [DATA_W:0] x_in;
   logic [DATA_W:0] y_in;
   logic            carry_in;
   logic [DATA_W:0] sum_in;
   logic [DATA_W:0] sum_ff;
   stage_ctl_type   ctl_in;
   stage_ctl_type   ctl_ff;

   // One extra sign bit makes overflow and the compare sign fall out of the same sum.
   assign first_ext  = {first_op[DATA_W-1], first_op};
   assign second_ext = {second_op[DATA_W-1], second_op};

   always_comb begin
      unique case (ctl.op) inside
         OP_ADD: begin
            x_in     = first_ext;
            y_in     = second_ext;
            carry_in = 1'b0;
         end
         OP_SUB, OP_CMP: begin
            x_in     = first_ext;
            y_in     = ~second_ext;
            carry_in = 1'b1;
         end
         OP_NEG: begin
            x_in     = '0;
            y_in     = ~first_ext;
            carry_in = 1'b1;
         end
      endcase
   end

   assign sum_in = x_in + y_in + {{DATA_W{1'b0}}, carry_in};
   assign ctl_in = ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.op <= ctl_in.op;
      sum_ff    <= sum_in;
   end

   assign ctl_out = ctl_ff;
   assign sum_out = sum_ff;

endmodule

FILE: rtl/wsasc_length.sv
// Result shaping: flags, order and the minimal byte length, over two register stages.
module wsasc_length #(
   parameter int unsigned DATA_W     = 256,
   parameter int unsigned BYTE_COUNT = 32,
   parameter int unsigned LEN_W      = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wsasc_pkg::stage_ctl_type  ctl,
   input  logic [DATA_W:0]           sum,
   output logic                      rsp_valid,
   output logic [DATA_W-1:0]         rsp_result,
   output logic                      rsp_overflow,
   output wsasc_pkg::order_type      rsp_order,
   output logic [LEN_W-1:0]          rsp_length
);
   import wsasc_pkg::*;

   // First stage: per-byte flags.
   logic [DATA_W-1:0]     result_in;
   logic                  overflow_in;
   order_type             order_in;
   logic                  zero_in;
   logic                  neg_in;
   logic [BYTE_COUNT-1:0] differ_in;
   logic [BYTE_COUNT-1:0] extra_in;
   stage_ctl_type         ctl_in;

   logic [DATA_W-1:0]     result_ff;
   logic                  overflow_ff;
   order_type             order_ff;
   logic                  zero_ff;
   logic [BYTE_COUNT-1:0] differ_ff;
   logic [BYTE_COUNT-1:0] extra_ff;
   stage_ctl_type         ctl_ff;

   // Second stage: the leading-byte search and the output register.
   logic [LEN_W-1:0]      top_count;
   logic                  top_extra;
   logic [LEN_W-1:0]      length_in;

   logic                  out_valid_ff;
   opcode_type            out_op_ff;
   logic [DATA_W-1:0]     out_result_ff;
   logic                  out_overflow_ff;
   order_type             out_order_ff;
   logic [LEN_W-1:0]      out_length_ff;

   assign neg_in = sum[DATA_W-1];
   assign ctl_in = ctl;

   always_comb begin
      if (ctl.op == OP_CMP) begin
         result_in   = '0;
         overflow_in = 1'b0;
         zero_in     = 1'b1;
         if (sum == '0) begin
            order_in = ORDER_EQUAL;
         end else if (sum[DATA_W]) begin
            order_in = ORDER_LESS;
         end else begin
            order_in = ORDER_GREATER;
         end
      end else begin
         result_in   = sum[DATA_W-1:0];
         overflow_in = sum[DATA_W] ^ sum[DATA_W-1];
         zero_in     = (sum[DATA_W-1:0] == '0);
         order_in    = ORDER_EQUAL;
      end
   end

   // A byte differs when it is not the pure sign fill; it needs an extra byte above
   // it when its own top bit disagrees with the sign.
   always_comb begin
      for (int i = 0; i < BYTE_COUNT; i++) begin
         differ_in[i] = (result_in[8*i +: 8] != {8{neg_in}});
         extra_in[i]  = (result_in[8*i + 7] != neg_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.op   <= ctl_in.op;
      result_ff   <= result_in;
      overflow_ff <= overflow_in;
      order_ff    <= order_in;
      zero_ff     <= zero_in;
      differ_ff   <= differ_in;
      extra_ff    <= extra_in;
   end

   always_comb begin
      top_count = '0;
      top_extra = 1'b0;
      for (int i = 0; i < BYTE_COUNT; i++) begin
         if (differ_ff[i]) begin
            top_count = LEN_W'(i + 1);
            top_extra = extra_ff[i];
         end
      end
   end

   always_comb begin
      if (zero_ff) begin
         length_in = '0;
      end else if (top_count == '0) begin
         length_in = LEN_W'(1);
      end else if (top_extra) begin
         length_in = top_count + LEN_W'(1);
      end else begin
         length_in = top_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= ctl_ff.valid;
      end
      out_op_ff       <= ctl_ff.op;
      out_result_ff   <= result_ff;
      out_overflow_ff <= overflow_ff;
      out_order_ff    <= order_ff;
      out_length_ff   <= length_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_result   = out_result_ff;
   assign rsp_overflow = out_overflow_ff;
   assign rsp_order    = out_order_ff;
   assign rsp_length   = out_length_ff;

   a_compare_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_op_ff == OP_CMP) |->
         (out_result_ff == '0 && !out_overflow_ff && out_length_ff == '0))
      else $error("compare item carries a result, overflow or length");

   a_order_only_compare: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_op_ff != OP_CMP) |-> (out_order_ff == ORDER_EQUAL))
      else $error("order set on an item that is not a compare");

   a_zero_length: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_op_ff != OP_CMP) |->
         ((out_length_ff == '0) == (out_result_ff == '0)))
      else $error("byte length zero does not match a zero result");

endmodule

FILE: rtl/wide_signed_add_sub_compare_unit.sv
// Top level of the wide signed add, subtract, negate and compare unit.
//
//   channel   direction  handshake               payload
//   request   in         start high, busy low    req_opcode, req_first_word*, req_second_word*
//   response  out        rsp_valid for one cycle rsp_sum_word*, rsp_overflow, rsp_order,
//                                                rsp_byte_length
//
// An item accepted at one clock edge passes four register stages: operand capture, the
// shared wide adder, the per-byte flag stage and the leading-byte search feeding the
// output register. It then appears on the response ports for exactly one cycle and is
// taken at the edge that ends that cycle. A new item may be accepted at every edge
// while busy is low.
// Reset is synchronous and clears every valid bit; busy is high while reset is held.
// The receiver cannot stall, so the pipeline never holds and busy is otherwise low.
module wide_signed_add_sub_compare_unit #(
   parameter int unsigned WORD_COUNT = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  wsasc_pkg::opcode_type              req_opcode,
   input  logic [wsasc_pkg::IN_WORD_W-1:0]    req_first_word0,
   input  logic [wsasc_pkg::IN_WORD_W-1:0]    req_first_word1,
   input  logic [wsasc_pkg::IN_WORD_W-1:0]    req_first_word2,
   input  logic [wsasc_pkg::IN_WORD_W-1:0]    req_first_word3,
   input  logic [wsasc_pkg::IN_WORD_W-1:0]    req_second_word0,
   input  logic [wsasc_pkg::IN_WORD_W-1:0]    req_second_word1,
   input  logic [wsasc_pkg::IN_WORD_W-1:0]    req_second_word2,
   input  logic [wsasc_pkg::IN_WORD_W-1:0]    req_second_word3,
   output logic                               rsp_valid,
   output logic [wsasc_pkg::IN_WORD_W-1:0]    rsp_sum_word0,
   output logic [wsasc_pkg::IN_WORD_W-1:0]    rsp_sum_word1,
   output logic [wsasc_pkg::IN_WORD_W-1:0]    rsp_sum_word2,
   output logic [wsasc_pkg::IN_WORD_W-1:0]    rsp_sum_word3,
   output logic                               rsp_overflow,
   output wsasc_pkg::order_type               rsp_order,
   output logic [wsasc_pkg::LEN_OUT_W-1:0]    rsp_byte_length
);
   import wsasc_pkg::*;

   // The operands are used at WORD_COUNT 32-bit words, with the sign at the top bit.
   localparam int unsigned DATA_W     = WORD_COUNT * 32;
   localparam int unsigned BYTE_COUNT = WORD_COUNT * 4;
   localparam int unsigned LEN_W      = $clog2(BYTE_COUNT + 1);

   logic [OUT_W-1:0]  first_full;
   logic [OUT_W-1:0]  second_full;
   logic              accept;

   stage_ctl_type     ctl_in;
   stage_ctl_type     ctl_ff;
   logic [DATA_W-1:0] first_in;
   logic [DATA_W-1:0] first_ff;
   logic [DATA_W-1:0] second_in;
   logic [DATA_W-1:0] second_ff;

   stage_ctl_type     sum_ctl;
   logic [DATA_W:0]   sum;

   logic [DATA_W-1:0] result;
   logic [LEN_W-1:0]  length;
   logic [OUT_W-1:0]  result_full;

   // Nothing is taken while reset is held, since the reset clears the stage valid bits.
   assign busy   = reset;
   assign accept = start && !busy;

   assign first_full  = {req_first_word3, req_first_word2, req_first_word1, req_first_word0};
   assign second_full = {req_second_word3, req_second_word2, req_second_word1,
                         req_second_word0};

   // Only the used low words are kept; the adder extends them from their own sign bit.
   assign first_in     = first_full[DATA_W-1:0];
   assign second_in    = second_full[DATA_W-1:0];
   assign ctl_in.valid = accept;
   assign ctl_in.op    = req_opcode;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.op <= ctl_in.op;
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   wsasc_adder #(
      .DATA_W (DATA_W)
   ) u_adder (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_ff),
      .first_op  (first_ff),
      .second_op (second_ff),
      .ctl_out   (sum_ctl),
      .sum_out   (sum)
   );

   wsasc_length #(
      .DATA_W     (DATA_W),
      .BYTE_COUNT (BYTE_COUNT),
      .LEN_W      (LEN_W)
   ) u_length (
      .clock        (clock),
      .reset        (reset),
      .ctl          (sum_ctl),
      .sum          (sum),
      .rsp_valid    (rsp_valid),
      .rsp_result   (result),
      .rsp_overflow (rsp_overflow),
      .rsp_order    (rsp_order),
      .rsp_length   (length)
   );

   // The result leaves sign-extended to the full 256 bits.
   assign result_full     = OUT_W'($signed(result));
   assign rsp_sum_word0   = result_full[1*IN_WORD_W-1 -: IN_WORD_W];
   assign rsp_sum_word1   = result_full[2*IN_WORD_W-1 -: IN_WORD_W];
   assign rsp_sum_word2   = result_full[3*IN_WORD_W-1 -: IN_WORD_W];
   assign rsp_sum_word3   = result_full[4*IN_WORD_W-1 -: IN_WORD_W];
   assign rsp_byte_length = LEN_OUT_W'(length);

   a_item_delivered: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("accepted item did not reach the response ports after four cycles");

   a_no_invented_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("response strobe without an item accepted four cycles earlier");

endmodule

FILE: test/testbench.sv
// Self-checking testbench of the wide signed add, subtract, negate and compare unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wsasc_pkg::*;

   // The unit is built at its full width. The predictor follows the same word
   // count, so a narrower build only needs this one constant changed.
   localparam int unsigned WORD_COUNT = 8;
   localparam int unsigned USED_BITS  = WORD_COUNT * 32;

   // Items may be accepted every cycle while busy is low. The drain time at the end
   // is based on the pipeline depth; the watchdog limit is a separate constant.
   localparam int unsigned PIPE_DEPTH  = 4;
   localparam int unsigned QUIET_LIMIT = 200;
   localparam int unsigned RANDOM_ITEMS = 450;

   localparam logic [255:0] MOST_POSITIVE = {1'b0, {255{1'b1}}};
   localparam logic [255:0] MOST_NEGATIVE = {1'b1, {255{1'b0}}};
   localparam logic [255:0] MINUS_ONE     = {256{1'b1}};

   // What one item is predicted to produce.
   typedef struct {
      logic [255:0]          sum;
      logic                  overflow;
      order_type             order;
      logic [LEN_OUT_W-1:0]  byte_length;
   } alu_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   opcode_type            req_opcode;
   logic [IN_WORD_W-1:0]  req_first_word0;
   logic [IN_WORD_W-1:0]  req_first_word1;
   logic [IN_WORD_W-1:0]  req_first_word2;
   logic [IN_WORD_W-1:0]  req_first_word3;
   logic [IN_WORD_W-1:0]  req_second_word0;
   logic [IN_WORD_W-1:0]  req_second_word1;
   logic [IN_WORD_W-1:0]  req_second_word2;
   logic [IN_WORD_W-1:0]  req_second_word3;
   logic                  rsp_valid;
   logic [IN_WORD_W-1:0]  rsp_sum_word0;
   logic [IN_WORD_W-1:0]  rsp_sum_word1;
   logic [IN_WORD_W-1:0]  rsp_sum_word2;
   logic [IN_WORD_W-1:0]  rsp_sum_word3;
   logic                  rsp_overflow;
   order_type             rsp_order;
   logic [LEN_OUT_W-1:0]  rsp_byte_length;

   // Outcomes of accepted items, oldest first, waiting for their results.
   alu_outcome_type pending_outcomes[$];
   alu_outcome_type oldest_outcome;
   logic [255:0] observed_sum;
   int unsigned  mismatch_count;
   int unsigned  quiet_cycles;
   // When clear, the sender drives items back to back with no idle cycles.
   bit           idle_allowed;

   wide_signed_add_sub_compare_unit #(
      .WORD_COUNT(WORD_COUNT)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_first_word0 (req_first_word0),
      .req_first_word1 (req_first_word1),
      .req_first_word2 (req_first_word2),
      .req_first_word3 (req_first_word3),
      .req_second_word0(req_second_word0),
      .req_second_word1(req_second_word1),
      .req_second_word2(req_second_word2),
      .req_second_word3(req_second_word3),
      .rsp_valid       (rsp_valid),
      .rsp_sum_word0   (rsp_sum_word0),
      .rsp_sum_word1   (rsp_sum_word1),
      .rsp_sum_word2   (rsp_sum_word2),
      .rsp_sum_word3   (rsp_sum_word3),
      .rsp_overflow    (rsp_overflow),
      .rsp_order       (rsp_order),
      .rsp_byte_length (rsp_byte_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Keeps the low USED_BITS of a value and copies its sign bit into every bit
   // above them. At the full width this leaves the value unchanged.
   function automatic logic [255:0] fit_width(logic [255:0] value);
      return $signed(value << (256 - USED_BITS)) >>> (256 - USED_BITS);
   endfunction

   // Fewest little-endian bytes whose sign extension gives the value; a zero
   // value takes no bytes at all. A top byte whose high bit disagrees with the
   // sign needs one more byte above it, even in the middle of a word.
   function automatic logic [LEN_OUT_W-1:0] minimal_byte_count(logic [255:0] value);
      int unsigned kept;
      logic        negative;
      logic [7:0]  fill;
      negative = value[USED_BITS-1];
      fill     = negative ? 8'hff : 8'h00;
      kept     = USED_BITS / 8;
      if (value == '0) begin
         return '0;
      end
      while (kept > 0 && value[8*(kept-1) +: 8] == fill) begin
         kept--;
      end
      if (kept == 0) begin
         return LEN_OUT_W'(1);
      end
      if (value[8*kept-1] != negative) begin
         return LEN_OUT_W'(kept + 1);
      end
      return LEN_OUT_W'(kept);
   endfunction

   // Works out what the unit must return for one item.
   function automatic alu_outcome_type predict_alu(opcode_type op, logic [255:0] first,
                                                   logic [255:0] second);
      alu_outcome_type outcome;
      logic [255:0] a;
      logic [255:0] b;
      logic [255:0] r;
      logic         a_neg;
      logic         b_neg;
      logic         r_neg;
      a     = fit_width(first);
      b     = fit_width(second);
      r     = '0;
      a_neg = a[USED_BITS-1];
      b_neg = b[USED_BITS-1];
      outcome.overflow    = 1'b0;
      outcome.order       = ORDER_EQUAL;
      outcome.byte_length = '0;
      case (op)
         OP_ADD: begin
            r     = fit_width(a + b);
            r_neg = r[USED_BITS-1];
            outcome.overflow = (a_neg == b_neg) && (r_neg != a_neg);
         end
         OP_SUB: begin
            r     = fit_width(a - b);
            r_neg = r[USED_BITS-1];
            outcome.overflow = (a_neg != b_neg) && (r_neg != a_neg);
         end
         OP_NEG: begin
            r     = fit_width(256'd0 - a);
            r_neg = r[USED_BITS-1];
            outcome.overflow = a_neg && r_neg;
         end
         default: begin
            if ($signed(a) < $signed(b)) begin
               outcome.order = ORDER_LESS;
            end else if ($signed(a) > $signed(b)) begin
               outcome.order = ORDER_GREATER;
            end
         end
      endcase
      outcome.sum = r;
      if (op != OP_CMP) begin
         outcome.byte_length = minimal_byte_count(r);
      end
      return outcome;
   endfunction

   // Drives one item after a random number of idle cycles and holds it until
   // the unit takes it. Inputs change only at the falling edge, and busy is
   // read at the rising edge, so acceptance is judged on settled values.
   task automatic issue_item(input opcode_type op, input logic [255:0] first,
                             input logic [255:0] second);
      int unsigned idle_cycles;
      idle_cycles = idle_allowed ? $urandom_range(0, 6) : 0;
      repeat (idle_cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start            = 1'b1;
      req_opcode       = op;
      req_first_word0  = first[63:0];
      req_first_word1  = first[127:64];
      req_first_word2  = first[191:128];
      req_first_word3  = first[255:192];
      req_second_word0 = second[63:0];
      req_second_word1 = second[127:64];
      req_second_word2 = second[191:128];
      req_second_word3 = second[255:192];
      do begin
         @(posedge clock);
      end while (busy);
      pending_outcomes.push_back(predict_alu(op, first, second));
   endtask

   // Draws an operand from a mix of shapes: fully random words, short values
   // of either sign, the extremes, and values next to a power of two.
   function automatic logic [255:0] random_operand();
      logic [255:0] value;
      int unsigned  bits;
      int unsigned  shift;
      for (int i = 0; i < 8; i++) begin
         value[32*i +: 32] = $urandom();
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
         end
         4, 5, 6: begin
            bits  = $urandom_range(1, 256);
            value = $signed(value << (256 - bits)) >>> (256 - bits);
         end
         7: begin
            case ($urandom_range(0, 4))
               0: value = '0;
               1: value = MINUS_ONE;
               2: value = MOST_POSITIVE;
               3: value = MOST_NEGATIVE;
               default: value = 256'd1;
            endcase
         end
         default: begin
            shift = $urandom_range(0, 255);
            value = (256'd1 << shift) + $urandom_range(0, 2) - 256'd1;
            if ($urandom_range(0, 1) == 1) begin
               value = 256'd0 - value;
            end
         end
      endcase
      return value;
   endfunction

   // Sums at the edge of the signed range, in both directions, with and
   // without overflow, plus the byte-length boundaries of the result.
   task automatic test_add_sub_limits();
      issue_item(OP_ADD, MOST_POSITIVE, 256'd1);
      issue_item(OP_ADD, MOST_NEGATIVE, MINUS_ONE);
      issue_item(OP_ADD, MOST_POSITIVE, MOST_NEGATIVE);
      issue_item(OP_ADD, '0, '0);
      issue_item(OP_ADD, 256'h7f, 256'h1);
      issue_item(OP_ADD, MINUS_ONE, MINUS_ONE);
      issue_item(OP_SUB, MOST_NEGATIVE, 256'd1);
      issue_item(OP_SUB, MOST_POSITIVE, MINUS_ONE);
      issue_item(OP_SUB, '0, 256'h80);
      issue_item(OP_SUB, 256'h81, 256'h1);
      // A positive result whose low word has bit 31 set needs a fifth byte.
      issue_item(OP_SUB, 256'h7fff_ffff, MINUS_ONE);
      issue_item(OP_SUB, MOST_NEGATIVE, MOST_NEGATIVE);
   endtask

   // Negation of zero, of the most negative value (the only overflow), and
   // of values around the one-byte boundary. The second operand is ignored.
   task automatic test_negate();
      issue_item(OP_NEG, '0, random_operand());
      issue_item(OP_NEG, MOST_NEGATIVE, random_operand());
      issue_item(OP_NEG, MOST_POSITIVE, random_operand());
      issue_item(OP_NEG, 256'd1, random_operand());
      issue_item(OP_NEG, 256'h80, random_operand());
      issue_item(OP_NEG, 256'h81, random_operand());
   endtask

   // Ordering across the sign boundary, equality, and a difference that shows
   // only in the lowest word. Every sum field must come back zero.
   task automatic test_compare();
      issue_item(OP_CMP, MOST_NEGATIVE, MOST_POSITIVE);
      issue_item(OP_CMP, MOST_POSITIVE, MOST_NEGATIVE);
      issue_item(OP_CMP, MINUS_ONE, '0);
      issue_item(OP_CMP, MOST_POSITIVE, MOST_POSITIVE);
      issue_item(OP_CMP, MOST_POSITIVE - 256'd1, MOST_POSITIVE);
   endtask

   // Random items of every operation. The second operand is sometimes tied
   // to the first so that equal, nearly equal, complementary and opposite
   // pairs come up often. Idle gaps are switched off in some stretches.
   task automatic test_random_mix();
      logic [255:0] first;
      logic [255:0] second;
      opcode_type   op;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            idle_allowed = ($urandom_range(0, 3) != 0);
         end
         op    = opcode_type'($urandom_range(0, 3));
         first = random_operand();
         case ($urandom_range(0, 7))
            0: second = first;
            1: second = first ^ (256'd1 << $urandom_range(0, 255));
            2: second = ~first;
            3: second = 256'd0 - first;
            default: second = random_operand();
         endcase
         issue_item(op, first, second);
      end
      idle_allowed = 1'b1;
   endtask

   // Each result is taken at the rising edge that ends its one valid cycle
   // and compared field by field with the oldest outcome still waiting.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("result arrived with no item outstanding");
            mismatch_count++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            observed_sum   = {rsp_sum_word3, rsp_sum_word2, rsp_sum_word1, rsp_sum_word0};
            for (int w = 0; w < 4; w++) begin
               if (observed_sum[64*w +: 64] !== oldest_outcome.sum[64*w +: 64]) begin
                  $error("sum_word%0d: expected %h, actual %h", w,
                         oldest_outcome.sum[64*w +: 64], observed_sum[64*w +: 64]);
                  mismatch_count++;
               end
            end
            if (rsp_overflow !== oldest_outcome.overflow) begin
               $error("overflow: expected %b, actual %b",
                      oldest_outcome.overflow, rsp_overflow);
               mismatch_count++;
            end
            if (rsp_order !== oldest_outcome.order) begin
               $error("order: expected %0d, actual %0d",
                      oldest_outcome.order, rsp_order);
               mismatch_count++;
            end
            if (rsp_byte_length !== oldest_outcome.byte_length) begin
               $error("byte_length: expected %0d, actual %0d",
                      oldest_outcome.byte_length, rsp_byte_length);
               mismatch_count++;
            end
         end
      end
   end

   // The run is stopped if neither an item nor a result moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      mismatch_count   = 0;
      quiet_cycles     = 0;
      idle_allowed     = 1'b1;
      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = OP_ADD;
      req_first_word0  = '0;
      req_first_word1  = '0;
      req_first_word2  = '0;
      req_first_word3  = '0;
      req_second_word0 = '0;
      req_second_word1 = '0;
      req_second_word2 = '0;
      req_second_word3 = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_add_sub_limits();
      test_negate();
      test_compare();
      test_random_mix();

      @(negedge clock);
      start = 1'b0;
      // Wait for every outstanding result, then go on waiting so that a stray
      // extra result would still be caught.
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
